/* rtl/led_pattern_sequencer_macros.svh */
// ----------------------------------------------------------------------------
// LED pattern sequencer assertion macros
// Concurrent assertion shorthands on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_MACROS_SVH
`define LED_PATTERN_SEQUENCER_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define LPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define LPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/lps_pkg.sv */
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared types, default sizes, pattern ROM contents and channel tables.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  // Default sizes
  localparam int unsigned CHANNELS_DEF    = 4;
  localparam int unsigned STACK_DEPTH_DEF = 3;
  localparam int unsigned TIME_BITS_DEF   = 32;

  // Channels that have a mask bit and an output bit
  localparam int unsigned LED_CHANNELS = 4;

  localparam int unsigned PAT_COUNT = 5;

  typedef logic [2:0] pat_t;
  typedef logic [5:0] rpos_t;
  typedef logic [7:0] code_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  // Delay bytes with a control meaning
  localparam code_t CODE_RESTART = 8'd255;
  localparam code_t CODE_POP     = 8'd254;
  localparam code_t CODE_HOLD    = 8'd0;

  localparam pat_t PAT_OFF = 3'd0;

  // Mask bit and start offset per channel index (ch1, ch2, ch3, ch4)
  localparam logic [1:0] MASK_SEL [LED_CHANNELS]  = '{2'd3, 2'd1, 2'd2, 2'd0};
  localparam logic [3:0] START_OFF [LED_CHANNELS] = '{4'd2, 4'd6, 4'd4, 4'd8};

  // Pattern ROM; addresses outside the patterns read as restart
  function automatic code_t rom_read(rpos_t pos);
    code_t val;
    case (pos)
      6'd0, 6'd1, 6'd2, 6'd6, 6'd7, 6'd19: val = 8'd0;
      6'd5, 6'd10, 6'd16, 6'd22, 6'd23:    val = 8'd1;
      6'd11, 6'd17:                        val = 8'd2;
      6'd12, 6'd18:                        val = 8'd125;
      6'd13:                               val = 8'd62;
      6'd24, 6'd26, 6'd28, 6'd30, 6'd32,
      6'd34, 6'd36, 6'd38:                 val = 8'd200;
      6'd25, 6'd27, 6'd29, 6'd31, 6'd33,
      6'd35, 6'd37, 6'd39:                 val = 8'd50;
      6'd40, 6'd41:                        val = CODE_POP;
      default:                             val = CODE_RESTART;
    endcase
    return val;
  endfunction

  // First ROM address of a pattern; unknown patterns fall back to off
  function automatic rpos_t pat_base(pat_t pat);
    rpos_t base;
    case (pat)
      3'd1:    base = 6'd5;
      3'd2:    base = 6'd10;
      3'd3:    base = 6'd16;
      3'd4:    base = 6'd22;
      default: base = 6'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

/* rtl/lps_if.sv */
// ----------------------------------------------------------------------------
// LED pattern sequencer channels
// Valid/ready interfaces for the command items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lps_in_if #(
  parameter int unsigned TIME_BITS = lps_pkg::TIME_BITS_DEF
);
  import lps_pkg::*;

  logic                 valid;
  logic                 ready;
  op_e                  op;
  logic [TIME_BITS-1:0] now_time;
  logic [3:0]           channel_mask;
  pat_t                 pattern_id;
  logic                 launching;

  modport source (
    output valid, op, now_time, channel_mask, pattern_id, launching,
    input  ready
  );

  modport sink (
    input  valid, op, now_time, channel_mask, pattern_id, launching,
    output ready
  );
endinterface

interface lps_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_levels;
  logic [3:0] led_written;

  modport source (
    output valid, led_levels, led_written,
    input  ready
  );

  modport sink (
    input  valid, led_levels, led_written,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/led_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// LED pattern sequencer
// Per-channel byte-coded blink patterns driven by timer ticks and start items.
// ----------------------------------------------------------------------------
// One item is taken per clock while results are taken. Each accepted item
// lands in an input register; from there every channel is evaluated at once
// (expiry subtract, pattern ROM lookup, deadline add) and the result
// register is loaded when it is empty or its result is being taken; the
// result is offered from there. While a result waits to be taken, the input
// register can still take one more item; after that ready stays low until
// the result is taken. There is no start-up sweep: the block is ready right
// after reset with all channels playing the off pattern.
`default_nettype none
`include "led_pattern_sequencer_macros.svh"

module led_pattern_sequencer #(
  parameter int unsigned CHANNELS    = lps_pkg::CHANNELS_DEF,
  parameter int unsigned STACK_DEPTH = lps_pkg::STACK_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = lps_pkg::TIME_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lps_in_if.sink      in_if,
  lps_out_if.source   out_if
);
  import lps_pkg::*;

  localparam int unsigned TB     = TIME_BITS;
  localparam int unsigned CH_EXT = (CHANNELS > LED_CHANNELS) ? CHANNELS : LED_CHANNELS;

  localparam logic [TB-1:0] EXPIRE_LIMIT = {1'b0, {(TB-1){1'b1}}};
  localparam logic [TB-1:0] HOLD_TICKS   = EXPIRE_LIMIT - TB'(1);

  // Input register
  logic          s1_valid_q;
  op_e           s1_op_q;
  logic [TB-1:0] s1_now_q;
  logic [3:0]    s1_mask_q;
  pat_t          s1_pat_q;
  logic          s1_launch_q;

  // Result register
  logic       out_valid_q;
  logic [3:0] out_levels_q, out_levels_d;
  logic [3:0] out_written_q, out_written_d;

  // Channel state
  logic [TB-1:0] deadline_q [CHANNELS];
  logic [TB-1:0] deadline_d [CHANNELS];
  rpos_t         pos_q      [CHANNELS];
  rpos_t         pos_d      [CHANNELS];
  pat_t          stack_q    [CHANNELS][STACK_DEPTH];
  pat_t          stack_d    [CHANNELS][STACK_DEPTH];
  logic          level_q    [CHANNELS];
  logic          level_d    [CHANNELS];
  logic [1:0]    scale_q    [CHANNELS];
  logic [1:0]    scale_d    [CHANNELS];
  logic [3:0]    driven_q, driven_d;

  // Per-channel working values
  pat_t          stk_ext   [CHANNELS][STACK_DEPTH+1];
  logic [TB-1:0] diff      [CHANNELS];
  code_t         code      [CHANNELS];
  logic          reload    [CHANNELS];
  pat_t          top_pat   [CHANNELS];
  rpos_t         base      [CHANNELS];
  code_t         head_lvl  [CHANNELS];
  code_t         head_scl  [CHANNELS];
  rpos_t         rpos      [CHANNELS];
  code_t         delay8    [CHANNELS];
  logic [1:0]    scl       [CHANNELS];
  logic [TB-1:0] delay     [CHANNELS];
  logic          fire      [CH_EXT];
  logic          lvl       [CH_EXT];
  rpos_t         st_base;
  code_t         st_lvl;
  code_t         st_scl;

  logic advance;
  logic is_tick;
  logic is_start;

  assign advance  = s1_valid_q && (!out_valid_q || out_if.ready);
  assign is_tick  = (s1_op_q == OP_TICK) && !s1_launch_q;
  assign is_start = (s1_op_q == OP_START) && (s1_pat_q < pat_t'(PAT_COUNT));

  assign in_if.ready = !s1_valid_q || advance;

  // Capture the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_op_q     <= in_if.op;
      s1_now_q    <= in_if.now_time;
      s1_mask_q   <= in_if.channel_mask;
      s1_pat_q    <= in_if.pattern_id;
      s1_launch_q <= in_if.launching;
    end
  end

  // Evaluate every channel for a tick
  always_comb begin
    for (int c = 0; c < CH_EXT; c++) begin
      fire[c] = 1'b0;
      lvl[c]  = 1'b0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < STACK_DEPTH; k++) begin
        stk_ext[c][k] = stack_q[c][k];
      end
      stk_ext[c][STACK_DEPTH] = PAT_OFF;

      diff[c]     = s1_now_q - deadline_q[c];
      fire[c]     = is_tick && (diff[c] < EXPIRE_LIMIT);
      code[c]     = rom_read(pos_q[c]);
      reload[c]   = (code[c] == CODE_RESTART) || (code[c] == CODE_POP);
      top_pat[c]  = (code[c] == CODE_POP) ? stk_ext[c][1] : stack_q[c][0];
      base[c]     = pat_base(top_pat[c]);
      head_lvl[c] = rom_read(base[c]);
      head_scl[c] = rom_read(base[c] + 6'd1);
      lvl[c]      = reload[c] ? head_lvl[c][0] : level_q[c];
      scl[c]      = reload[c] ? head_scl[c][1:0] : scale_q[c];
      rpos[c]     = reload[c] ? (base[c] + 6'd2) : pos_q[c];
      delay8[c]   = reload[c] ? rom_read(base[c] + 6'd2) : code[c];
      if (delay8[c] == CODE_HOLD) begin
        delay[c] = HOLD_TICKS;
      end else begin
        delay[c] = TB'(delay8[c]) << scl[c];
      end
    end
  end

  // Update channel state and build the result
  always_comb begin
    deadline_d = deadline_q;
    pos_d      = pos_q;
    stack_d    = stack_q;
    level_d    = level_q;
    scale_d    = scale_q;
    driven_d   = driven_q;
    st_base    = pat_base(s1_pat_q);
    st_lvl     = rom_read(st_base);
    st_scl     = rom_read(st_base + 6'd1);
    out_written_d = '0;

    if (advance && is_tick) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (fire[c]) begin
          if (code[c] == CODE_POP) begin
            for (int k = 0; k < STACK_DEPTH; k++) begin
              stack_d[c][k] = stk_ext[c][k+1];
            end
          end
          level_d[c]    = ~lvl[c];
          scale_d[c]    = scl[c];
          pos_d[c]      = rpos[c] + 6'd1;
          deadline_d[c] = deadline_q[c] + delay[c];
        end
      end
      for (int c = 0; c < LED_CHANNELS; c++) begin
        if (fire[c]) begin
          driven_d[c]      = lvl[c];
          out_written_d[c] = 1'b1;
        end
      end
    end else if (advance && is_start) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (c < LED_CHANNELS && s1_mask_q[MASK_SEL[c]]) begin
          for (int k = 1; k < STACK_DEPTH; k++) begin
            stack_d[c][k] = stack_q[c][k-1];
          end
          stack_d[c][0] = s1_pat_q;
          level_d[c]    = st_lvl[0];
          scale_d[c]    = st_scl[1:0];
          pos_d[c]      = st_base + 6'd2;
          deadline_d[c] = s1_now_q + TB'(START_OFF[c]);
        end
      end
    end

    out_levels_d = driven_d;
  end

  // Hold channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        deadline_q[c] <= HOLD_TICKS;
        pos_q[c]      <= pat_base(PAT_OFF) + 6'd2;
        level_q[c]    <= 1'b0;
        scale_q[c]    <= 2'd0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
          stack_q[c][k] <= PAT_OFF;
        end
      end
      driven_q <= '0;
    end else begin
      deadline_q <= deadline_d;
      pos_q      <= pos_d;
      level_q    <= level_d;
      scale_q    <= scale_d;
      stack_q    <= stack_d;
      driven_q   <= driven_d;
    end
  end

  // Offer the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_levels_q  <= out_levels_d;
      out_written_q <= out_written_d;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.led_levels  = out_levels_q;
  assign out_if.led_written = out_written_q;

  // Start items and ignored ticks drive no channel
  `LPS_ASSERT(a_no_write_on_start,
    advance && !(s1_op_q == OP_TICK && !s1_launch_q) |=> out_if.led_written == 4'd0,
    "channel driven by a start item or an ignored tick")

  // Only driven channels change their reported level
  `LPS_ASSERT(a_levels_follow_writes,
    advance |=> ((out_if.led_levels ^ $past(driven_q)) & ~out_if.led_written) == 4'd0,
    "level changed on a channel that was not driven")

  // Channel 1 start sets its deadline two ticks ahead
  `LPS_ASSERT(a_ch1_start_deadline,
    advance && is_start && s1_mask_q[MASK_SEL[0]]
      |=> deadline_q[0] == $past(s1_now_q + TB'(START_OFF[0])),
    "channel 1 deadline wrong after start")

  // Nothing is offered while in reset
  `LPS_ASSERT_ALWAYS(a_idle_in_reset,
    !rst_ni |-> !out_if.valid && !s1_valid_q,
    "item or result present during reset")

endmodule

`default_nettype wire
